// ===== src/rrm_pkg.sv =====
package rrm_pkg;

  localparam int MaxFieldBytes = 8;

  localparam int ClusterBytesW = 22;
  localparam logic [ClusterBytesW-1:0] ClusterBytesReset = 22'd4096;

  // register index taken from paddr[2]
  localparam logic RegClusterBytes = 1'b0;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } rrm_op_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_END  = 1'b1
  } rrm_kind_e;

  typedef struct packed {
    rrm_op_e     opcode;
    logic [47:0] start_cluster;
    logic [47:0] start_offset;
    logic [47:0] byte_count;
    logic [7:0]  runlist_byte;
  } rrm_in_t;

  typedef struct packed {
    rrm_kind_e   kind;
    logic [63:0] volume_address;
    logic [47:0] read_length;
    logic [47:0] bytes_left;
    logic        last;
  } rrm_out_t;

endpackage

// ===== src/runlist_read_mapper.sv =====
// A result passes through the p1 to p5 pipeline registers and then the output register.
// Throughput: one item per cycle unless the output stalls; five pipeline registers plus the
//   output register let beats that cause no result keep flowing while a result waits to be taken.
// The 64x22 cluster products are split into 32-bit partial products over two stages.
// Reset (rst_ni low, async): pipeline and output empty, parser idle, cluster_bytes = 4096.
//   No clearing pass; items are taken as soon as reset is released.
module runlist_read_mapper (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrm_pkg::rrm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrm_pkg::rrm_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rrm_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_COUNT,
    PH_DELTA
  } phase_e;

  typedef enum logic [1:0] {
    PO_START,
    PO_FIN,
    PO_END
  } pop_e;

  typedef struct packed {
    pop_e        op;
    logic [63:0] cl;   // start cluster, or sign-extended delta
    logic [63:0] rc;
    logic [47:0] off;
    logic [47:0] cnt;
  } p1_t;

  typedef struct packed {
    pop_e        op;
    logic [63:0] cc;
    logic [63:0] rc;
    logic [47:0] off;
    logic [47:0] cnt;
  } p2_t;

  typedef struct packed {
    pop_e        op;
    logic [53:0] lo_a;
    logic [53:0] lo_b;
    logic [31:0] hi_a;
    logic [31:0] hi_b;
    logic [47:0] off;
    logic [47:0] cnt;
  } p3_t;

  typedef struct packed {
    pop_e        op;
    logic [63:0] abase;
    logic [63:0] rb;
    logic [47:0] off;
    logic [47:0] cnt;
  } p4_t;

  typedef struct packed {
    pop_e        op;
    logic        skip;
    logic [63:0] room;
    logic [63:0] addr;
    logic [47:0] cnt;
  } p5_t;

  // ---------------- configuration ----------------
  logic [ClusterBytesW-1:0] cb_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegClusterBytes);
  assign prdata = (paddr[2] == RegClusterBytes) ? {{(32-ClusterBytesW){1'b0}}, cb_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q <= ClusterBytesReset;
    end else if (cfg_wr) begin
      cb_q <= pwdata[ClusterBytesW-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, out_v_q;
  logic free1, free2, free3, free4, free5, out_free, p5_res, adv5;
  logic in_fire;

  p1_t p1_q, p1_d;
  p2_t p2_q, p2_d;
  p3_t p3_q, p3_d;
  p4_t p4_q, p4_d;
  p5_t p5_q, p5_d;
  rrm_out_t out_q, out_d;

  logic [47:0] cnt_q;
  logic        done_q;

  assign out_free = !out_v_q || out_ready_i;
  assign p5_res   = p5_v_q && !done_q &&
                    (((p5_q.op == PO_FIN) && !p5_q.skip) ||
                     ((p5_q.op == PO_END) && (cnt_q != 48'd0)));
  assign adv5     = p5_v_q && (!p5_res || out_free);
  assign free5    = !p5_v_q || adv5;
  assign free4    = !p4_v_q || free5;
  assign free3    = !p3_v_q || free4;
  assign free2    = !p2_v_q || free3;
  assign free1    = !p1_v_q || free2;

  assign in_ready_o = free1;
  assign in_fire    = in_valid_i && free1;

  // ---------------- stage 0: runlist parser ----------------
  phase_e      phase_q, phase_d;
  logic [3:0]  cw_q, cw_d, dw_q, dw_d, idx_q, idx_d;
  logic [63:0] rc_q, rc_d, da_q, da_d;
  logic        push;

  logic [3:0]  idx_inc, ew;
  logic [63:0] fold_val, rc_fold, da_fold, delta_sx;
  logic [5:0]  sgn_pos;
  logic        ext_ok;

  assign idx_inc  = idx_q + 4'd1;
  assign fold_val = (idx_q < 4'(MaxFieldBytes)) ?
                    ({56'd0, in_data_i.runlist_byte} << {idx_q[2:0], 3'b000}) : 64'd0;
  assign rc_fold  = rc_q | fold_val;
  assign da_fold  = da_q | fold_val;
  assign ew       = (dw_q > 4'(MaxFieldBytes)) ? 4'(MaxFieldBytes) : dw_q;
  assign ext_ok   = (ew != 4'd0) && (ew < 4'd8);
  assign sgn_pos  = {ew[2:0], 3'b000} - 6'd1;
  assign delta_sx = (ext_ok && da_fold[sgn_pos]) ?
                    (da_fold | ({64{1'b1}} << {ew[2:0], 3'b000})) : da_fold;

  always_comb begin
    phase_d = phase_q;
    cw_d    = cw_q;
    dw_d    = dw_q;
    idx_d   = idx_q;
    rc_d    = rc_q;
    da_d    = da_q;
    push    = 1'b0;
    p1_d    = '{op: PO_END, cl: 64'd0, rc: rc_q,
                off: in_data_i.start_offset, cnt: in_data_i.byte_count};
    if (in_fire) begin
      if (in_data_i.opcode == OP_START) begin
        phase_d = (in_data_i.byte_count != 48'd0) ? PH_HEADER : PH_IDLE;
        cw_d    = 4'd0;
        dw_d    = 4'd0;
        idx_d   = 4'd0;
        rc_d    = 64'd0;
        da_d    = 64'd0;
        push    = 1'b1;
        p1_d.op = PO_START;
        p1_d.cl = {16'd0, in_data_i.start_cluster};
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_HEADER: begin
            if (in_data_i.runlist_byte == 8'd0) begin
              phase_d = PH_IDLE;
              push    = 1'b1;
              p1_d.op = PO_END;
            end else begin
              cw_d    = in_data_i.runlist_byte[3:0];
              dw_d    = in_data_i.runlist_byte[7:4];
              idx_d   = 4'd0;
              rc_d    = 64'd0;
              da_d    = 64'd0;
              phase_d = (in_data_i.runlist_byte[3:0] != 4'd0) ? PH_COUNT : PH_DELTA;
            end
          end
          PH_COUNT: begin
            rc_d  = rc_fold;
            idx_d = idx_inc;
            if (idx_inc == cw_q) begin
              idx_d = 4'd0;
              if (dw_q != 4'd0) begin
                phase_d = PH_DELTA;
              end else begin
                // run ends with no delta: cluster stays put
                phase_d = PH_HEADER;
                push    = 1'b1;
                p1_d.op = PO_FIN;
                p1_d.cl = 64'd0;
                p1_d.rc = rc_fold;
              end
            end
          end
          PH_DELTA: begin
            da_d  = da_fold;
            idx_d = idx_inc;
            if (idx_inc == dw_q) begin
              idx_d   = 4'd0;
              phase_d = PH_HEADER;
              push    = 1'b1;
              p1_d.op = PO_FIN;
              p1_d.cl = delta_sx;
              p1_d.rc = rc_q;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cw_q    <= 4'd0;
      dw_q    <= 4'd0;
      idx_q   <= 4'd0;
      p1_v_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cw_q    <= cw_d;
      dw_q    <= dw_d;
      idx_q   <= idx_d;
      if (free1) begin
        p1_v_q <= push;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rc_q <= rc_d;
    da_q <= da_d;
    if (free1) begin
      p1_q <= p1_d;
    end
  end

  // ---------------- stage 1: current cluster ----------------
  logic [63:0] cc_q, cc_sum;

  assign cc_sum = cc_q + p1_q.cl;

  always_comb begin
    p2_d    = '{op: p1_q.op, cc: cc_sum, rc: p1_q.rc, off: p1_q.off, cnt: p1_q.cnt};
    if (p1_q.op == PO_START) begin
      p2_d.cc = p1_q.cl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free2) begin
      p2_q <= p2_d;
      if (p1_v_q && (p1_q.op == PO_START)) begin
        cc_q <= p1_q.cl;
      end else if (p1_v_q && (p1_q.op == PO_FIN)) begin
        cc_q <= cc_sum;
      end
    end
  end

  // ---------------- stage 2: low partial products ----------------
  always_comb begin
    p3_d.op   = p2_q.op;
    p3_d.lo_a = 54'(p2_q.cc[31:0]) * 54'(cb_q);
    p3_d.lo_b = 54'(p2_q.rc[31:0]) * 54'(cb_q);
    p3_d.hi_a = p2_q.cc[63:32];
    p3_d.hi_b = p2_q.rc[63:32];
    p3_d.off  = p2_q.off;
    p3_d.cnt  = p2_q.cnt;
  end

  always_ff @(posedge clk_i) begin
    if (free3) begin
      p3_q <= p3_d;
    end
  end

  // ---------------- stage 3: high partial products, sum mod 2^64 ----------------
  logic [53:0] hi_a_prod, hi_b_prod;

  assign hi_a_prod = 54'(p3_q.hi_a) * 54'(cb_q);
  assign hi_b_prod = 54'(p3_q.hi_b) * 54'(cb_q);

  always_comb begin
    p4_d.op    = p3_q.op;
    p4_d.abase = {10'd0, p3_q.lo_a} + {hi_a_prod[31:0], 32'd0};
    p4_d.rb    = {10'd0, p3_q.lo_b} + {hi_b_prod[31:0], 32'd0};
    p4_d.off   = p3_q.off;
    p4_d.cnt   = p3_q.cnt;
  end

  always_ff @(posedge clk_i) begin
    if (free4) begin
      p4_q <= p4_d;
    end
  end

  // ---------------- stage 4: offset into the runs ----------------
  logic [47:0] off_q;
  logic [63:0] off_ext;

  assign off_ext = {16'd0, off_q};

  always_comb begin
    p5_d.op   = p4_q.op;
    p5_d.skip = off_ext >= p4_q.rb;
    p5_d.room = p4_q.rb - off_ext;
    p5_d.addr = p4_q.abase + off_ext;
    p5_d.cnt  = p4_q.cnt;
  end

  always_ff @(posedge clk_i) begin
    if (free5) begin
      p5_q <= p5_d;
      if (p4_v_q && (p4_q.op == PO_START)) begin
        off_q <= p4_q.off;
      end else if (p4_v_q && (p4_q.op == PO_FIN)) begin
        off_q <= p5_d.skip ? (off_q - p4_q.rb[47:0]) : 48'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
    end else begin
      if (free2) begin
        p2_v_q <= p1_v_q;
      end
      if (free3) begin
        p3_v_q <= p2_v_q;
      end
      if (free4) begin
        p4_v_q <= p3_v_q;
      end
      if (free5) begin
        p5_v_q <= p4_v_q;
      end
    end
  end

  // ---------------- stage 5: byte count and result ----------------
  // done_q drops beats that follow the end of a request until the next start
  logic [63:0] cnt_ext;
  logic        cnt_lt, cnt_le;
  logic [47:0] cnt_diff;

  assign cnt_ext  = {16'd0, cnt_q};
  assign cnt_lt   = cnt_ext < p5_q.room;
  assign cnt_le   = cnt_ext <= p5_q.room;
  assign cnt_diff = cnt_q - p5_q.room[47:0];

  always_comb begin
    if (p5_q.op == PO_END) begin
      out_d = '{kind: KIND_END, volume_address: 64'd0, read_length: 48'd0,
                bytes_left: cnt_q, last: 1'b1};
    end else begin
      out_d = '{kind: KIND_READ, volume_address: p5_q.addr,
                read_length: cnt_lt ? cnt_q : p5_q.room[47:0],
                bytes_left: cnt_lt ? 48'd0 : cnt_diff, last: cnt_le};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b1;
      out_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q <= p5_res;
      end
      if (adv5) begin
        unique case (p5_q.op)
          PO_START: done_q <= 1'b0;
          PO_END:   done_q <= 1'b1;
          PO_FIN: begin
            if (!done_q && !p5_q.skip) begin
              done_q <= cnt_le;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && p5_res) begin
      out_q <= out_d;
    end
    if (adv5) begin
      if (p5_q.op == PO_START) begin
        cnt_q <= p5_q.cnt;
      end else if ((p5_q.op == PO_FIN) && !done_q && !p5_q.skip) begin
        cnt_q <= cnt_lt ? 48'd0 : cnt_diff;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // a read request never has zero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_READ)) |-> (out_data_o.read_length != 48'd0))
    else $error("read request with zero length");

  // last marks exactly the request that uses up the count
  a_last_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_READ)) |->
      (out_data_o.last == (out_data_o.bytes_left == 48'd0)))
    else $error("last flag disagrees with bytes_left");

  // an end beat carries a nonzero remainder and closes the request
  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_END)) |->
      (out_data_o.last && (out_data_o.bytes_left != 48'd0) &&
       (out_data_o.volume_address == 64'd0) && (out_data_o.read_length == 48'd0)))
    else $error("malformed end beat");

  // input stalls only when a result is stuck at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");
`endif

endmodule
